// ----- rtl/pst_pkg.sv -----
// shared types and constants for the polygon stream triangulator
package pst_pkg;

  // work kinds handed from the front to the back through the queue
  typedef enum logic [1:0] {
    KIND_TRI  = 2'd0,
    KIND_QUAD = 2'd1,
    KIND_DROP = 2'd2,
    KIND_ERR  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      split;  // quad: diagonal 0-2 strictly shorter than 1-3
  } cmd_ctl_t;

  localparam int CTL_BITS = $bits(cmd_ctl_t);

  localparam logic [1:0] STATUS_TRI  = 2'd0;
  localparam logic [1:0] STATUS_DROP = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  localparam logic [2:0] TRI_VERTS  = 3'd3;
  localparam logic [2:0] QUAD_VERTS = 3'd4;
  localparam logic [2:0] COUNT_MAX  = 3'd7;

  localparam int QUEUE_DEPTH = 4;

endpackage

// ----- rtl/pst_queue.sv -----
// small register queue between the front and the back
module pst_queue import pst_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign head  = entries[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + (AW+1)'(1);
      end
      if (pop) begin
        rptr <= rptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr[AW-1:0]] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) (push && !pop && !empty) |=> !empty)
    else $error("queue lost an entry");

endmodule

// ----- rtl/pst_front.sv -----
// front: takes stream items, keeps the open polygon and queues work for the back
module pst_front import pst_pkg::*; #(
  parameter int INDEX_BITS    = 20,
  parameter int COORD_BITS    = 20,
  parameter int POSITION_BITS = 24,
  parameter int ENTRY_W       = CTL_BITS + 2*POSITION_BITS + 4*INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [INDEX_BITS:0]          cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         first_of_mesh,
  input  logic                         is_terminator,
  input  logic [INDEX_BITS-1:0]        vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         push,
  output logic [ENTRY_W-1:0]           push_data,
  input  logic                         full
);

  localparam int DW = COORD_BITS + 1;
  localparam int QW = 2 * DW;
  localparam int SW = QW + 2;

  logic [INDEX_BITS:0]     vertex_count;
  logic [2:0]              poly_count;
  logic [POSITION_BITS-1:0] spos;
  logic [POSITION_BITS-1:0] start_pos;
  logic [POSITION_BITS-1:0] face;
  logic                    lock;

  logic [2:0]              poly_count_next;
  logic [POSITION_BITS-1:0] spos_next;
  logic [POSITION_BITS-1:0] start_pos_next;
  logic [POSITION_BITS-1:0] face_next;
  logic                    lock_next;

  logic [INDEX_BITS-1:0]        buf_idx [4];
  logic signed [COORD_BITS-1:0] buf_x   [4];
  logic signed [COORD_BITS-1:0] buf_y   [4];
  logic signed [COORD_BITS-1:0] buf_z   [4];

  // distance pipe: difference, squares, sum
  logic                 p1_valid;
  logic                 p1_sel;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dz;
  logic                 p2_valid;
  logic                 p2_sel;
  logic [QW-1:0]        sqx;
  logic [QW-1:0]        sqy;
  logic [QW-1:0]        sqz;
  logic [SW-1:0]        d02;
  logic [SW-1:0]        d13;

  logic [2:0]               eff_count;
  logic                     eff_lock;
  logic [POSITION_BITS-1:0] eff_spos;
  logic [POSITION_BITS-1:0] eff_start;
  logic [POSITION_BITS-1:0] eff_face;
  logic                     is_err;
  logic                     quad_term;
  logic                     do_push;
  logic                     pipe_busy;
  logic                     acc;
  logic                     store;
  logic [1:0]               pair_slot;
  cmd_ctl_t                 ctl;
  logic [POSITION_BITS-1:0] base;
  logic [INDEX_BITS-1:0]    idx0;

  assign eff_count = first_of_mesh ? 3'd0 : poly_count;
  assign eff_lock  = first_of_mesh ? 1'b0 : lock;
  assign eff_spos  = first_of_mesh ? '0 : spos;
  assign eff_start = first_of_mesh ? '0 : start_pos;
  assign eff_face  = first_of_mesh ? '0 : face;

  assign is_err    = !eff_lock && !is_terminator && ({1'b0, vertex_index} >= vertex_count);
  assign quad_term = !eff_lock && is_terminator && (eff_count == QUAD_VERTS);
  assign do_push   = !eff_lock && (is_terminator || is_err);
  assign pipe_busy = p1_valid || p2_valid;

  // a quad terminator waits for the second diagonal to land
  assign in_stall = (do_push && full) || (quad_term && pipe_busy);
  assign acc      = in_valid && !in_stall;
  assign push     = acc && do_push;
  assign store    = acc && !eff_lock && !is_terminator && !is_err;
  assign pair_slot = {1'b0, eff_count[0]};

  always_comb begin
    ctl.split = (d02 < d13);
    if (!is_terminator) begin
      ctl.kind = KIND_ERR;
    end else if (eff_count == TRI_VERTS) begin
      ctl.kind = KIND_TRI;
    end else if (eff_count == QUAD_VERTS) begin
      ctl.kind = KIND_QUAD;
    end else begin
      ctl.kind = KIND_DROP;
    end
    base = is_terminator ? eff_start : eff_spos;
    idx0 = is_terminator ? buf_idx[0] : vertex_index;
  end

  assign push_data = {ctl, eff_face, base, buf_idx[3], buf_idx[2], buf_idx[1], idx0};

  always_comb begin
    poly_count_next = poly_count;
    spos_next       = spos;
    start_pos_next  = start_pos;
    face_next       = face;
    lock_next       = lock;
    if (acc) begin
      poly_count_next = eff_count;
      spos_next       = eff_spos;
      start_pos_next  = eff_start;
      face_next       = eff_face;
      lock_next       = eff_lock;
      if (!eff_lock) begin
        if (is_terminator) begin
          spos_next       = eff_spos + POSITION_BITS'(1);
          start_pos_next  = eff_spos + POSITION_BITS'(1);
          face_next       = eff_face + POSITION_BITS'(1);
          poly_count_next = 3'd0;
        end else if (is_err) begin
          lock_next = 1'b1;
        end else begin
          if (eff_count != COUNT_MAX) begin
            poly_count_next = eff_count + 3'd1;
          end
          spos_next = eff_spos + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      poly_count   <= '0;
      spos         <= '0;
      start_pos    <= '0;
      face         <= '0;
      lock         <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      poly_count <= poly_count_next;
      spos       <= spos_next;
      start_pos  <= start_pos_next;
      face       <= face_next;
      lock       <= lock_next;
      p1_valid   <= store && ((eff_count == 3'd2) || (eff_count == 3'd3));
      p2_valid   <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (store && !eff_count[2]) begin
      buf_idx[eff_count[1:0]] <= vertex_index;
      buf_x[eff_count[1:0]]   <= coord_x;
      buf_y[eff_count[1:0]]   <= coord_y;
      buf_z[eff_count[1:0]]   <= coord_z;
    end
    // third vertex pairs with the first, fourth with the second
    p1_sel <= eff_count[0];
    dx     <= DW'(coord_x) - DW'(buf_x[pair_slot]);
    dy     <= DW'(coord_y) - DW'(buf_y[pair_slot]);
    dz     <= DW'(coord_z) - DW'(buf_z[pair_slot]);
    p2_sel <= p1_sel;
    sqx    <= QW'(dx * dx);
    sqy    <= QW'(dy * dy);
    sqz    <= QW'(dz * dz);
    if (p2_valid) begin
      if (p2_sel) begin
        d13 <= SW'(sqx) + SW'(sqy) + SW'(sqz);
      end else begin
        d02 <= SW'(sqx) + SW'(sqy) + SW'(sqz);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) (acc && quad_term) |-> !pipe_busy)
    else $error("quad split taken before its distances settled");
  assert property (@(posedge clk) disable iff (rst) $rose(lock) |-> $past(push))
    else $error("error lock set without an error transfer");
  assert property (@(posedge clk) disable iff (rst) p2_valid |-> $past(p1_valid))
    else $error("distance pipe out of step");

endmodule

// ----- rtl/pst_back.sv -----
// back: turns queued work into result transfers through an output register
module pst_back import pst_pkg::*; #(
  parameter int INDEX_BITS    = 20,
  parameter int POSITION_BITS = 24,
  parameter int ENTRY_W       = CTL_BITS + 2*POSITION_BITS + 4*INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ENTRY_W-1:0]       head,
  input  logic                     empty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [INDEX_BITS-1:0]    tri_vert_a,
  output logic [INDEX_BITS-1:0]    tri_vert_b,
  output logic [INDEX_BITS-1:0]    tri_vert_c,
  output logic [POSITION_BITS-1:0] src_pos_a,
  output logic [POSITION_BITS-1:0] src_pos_b,
  output logic [POSITION_BITS-1:0] src_pos_c,
  output logic [POSITION_BITS-1:0] face_number,
  output logic [1:0]               status,
  output logic                     last
);

  cmd_ctl_t                 head_ctl;
  logic [POSITION_BITS-1:0] head_face;
  logic [POSITION_BITS-1:0] head_base;
  logic [INDEX_BITS-1:0]    idx0;
  logic [INDEX_BITS-1:0]    idx1;
  logic [INDEX_BITS-1:0]    idx2;
  logic [INDEX_BITS-1:0]    idx3;

  logic phase;
  logic load;
  logic take;
  logic single;
  logic use_split;
  logic [1:0] sa;
  logic [1:0] sb;
  logic [1:0] sc;

  logic [INDEX_BITS-1:0]    va;
  logic [INDEX_BITS-1:0]    vb;
  logic [INDEX_BITS-1:0]    vc;
  logic [POSITION_BITS-1:0] pa;
  logic [POSITION_BITS-1:0] pb;
  logic [POSITION_BITS-1:0] pc;
  logic [1:0]               st;
  logic                     lst;

  assign {head_ctl, head_face, head_base, idx3, idx2, idx1, idx0} = head;

  assign load   = !out_valid || !out_stall;
  assign take   = load && !empty;
  assign single = (head_ctl.kind != KIND_QUAD);
  assign pop    = take && (single || phase);

  // a lone triangle reads like the first half of a quad split on 0-2
  assign use_split = (head_ctl.kind == KIND_TRI) ? 1'b1 : head_ctl.split;
  assign sa = (phase && !use_split) ? 2'd1 : 2'd0;
  assign sb = phase ? 2'd2 : 2'd1;
  assign sc = (!phase && !use_split) ? 2'd3 : 2'd2 + {1'b0, phase};

  always_comb begin
    va  = '0;
    vb  = '0;
    vc  = '0;
    pa  = '0;
    pb  = '0;
    pc  = '0;
    st  = STATUS_DROP;
    lst = 1'b1;
    case (head_ctl.kind)
      KIND_TRI, KIND_QUAD: begin
        va  = (sa == 2'd1) ? idx1 : idx0;
        vb  = (sb == 2'd2) ? idx2 : idx1;
        vc  = (sc == 2'd3) ? idx3 : idx2;
        pa  = head_base + POSITION_BITS'(sa);
        pb  = head_base + POSITION_BITS'(sb);
        pc  = head_base + POSITION_BITS'(sc);
        st  = STATUS_TRI;
        lst = single || phase;
      end
      KIND_ERR: begin
        va = idx0;
        pa = head_base;
        st = STATUS_ERR;
      end
      default: begin
        st = STATUS_DROP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        phase <= single ? 1'b0 : !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tri_vert_a  <= va;
      tri_vert_b  <= vb;
      tri_vert_c  <= vc;
      src_pos_a   <= pa;
      src_pos_b   <= pb;
      src_pos_c   <= pc;
      face_number <= head_face;
      status      <= st;
      last        <= lst;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   phase |-> (!empty && head_ctl.kind == KIND_QUAD))
    else $error("second half of a split without its quad at the head");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !last) |-> phase)
    else $error("first triangle of a quad shown without the second pending");
  assert property (@(posedge clk) disable iff (rst) $fell(phase) |-> $past(pop))
    else $error("split abandoned before the quad was retired");

endmodule

// ----- rtl/polygon_stream_triangulator.sv -----
// top level of the polygon stream triangulator
// Usage: the input channel carries one face-stream item per transfer (a vertex
// index with its fetched coordinates, or a polygon terminator); first_of_mesh
// restarts counters, the open polygon and the error lock. vertex_count is
// written through cfg_wr_en / cfg_wr_data while the block is idle.
// The output channel carries one result per transfer: a triangle, a dropped
// polygon or an out-of-range error; last marks the final result of an item.
// Throughput: one vertex per cycle, but an out-of-range vertex waits while
// the queue is full; a quad terminator gives two results, a triangle or
// dropped polygon terminator one. A quad terminator that closely follows its
// fourth vertex waits for the three-stage distance pipe (difference, square,
// sum). A terminator's first result goes through the queue, then the output
// register. A four-entry queue sits between the front and the output register,
// so vertices keep flowing while the receiver stalls; the front stalls when the
// queue is full and an item needs an entry, or a quad waits for the pipe.
// Reset (synchronous, rst high) clears vertex_count, all counters, the lock,
// the queue pointers and the output valid flag; no result is pending after reset.
module polygon_stream_triangulator import pst_pkg::*; #(
  parameter int INDEX_BITS    = 20,
  parameter int COORD_BITS    = 20,
  parameter int POSITION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [INDEX_BITS:0]          cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         first_of_mesh,
  input  logic                         is_terminator,
  input  logic [INDEX_BITS-1:0]        vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [INDEX_BITS-1:0]        tri_vert_a,
  output logic [INDEX_BITS-1:0]        tri_vert_b,
  output logic [INDEX_BITS-1:0]        tri_vert_c,
  output logic [POSITION_BITS-1:0]     src_pos_a,
  output logic [POSITION_BITS-1:0]     src_pos_b,
  output logic [POSITION_BITS-1:0]     src_pos_c,
  output logic [POSITION_BITS-1:0]     face_number,
  output logic [1:0]                   status,
  output logic                         last
);

  localparam int ENTRY_W = CTL_BITS + 2*POSITION_BITS + 4*INDEX_BITS;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_head;
  logic               q_empty;

  pst_front #(
    .INDEX_BITS    (INDEX_BITS),
    .COORD_BITS    (COORD_BITS),
    .POSITION_BITS (POSITION_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_of_mesh (first_of_mesh),
    .is_terminator (is_terminator),
    .vertex_index  (vertex_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .push          (q_push),
    .push_data     (q_push_data),
    .full          (q_full)
  );

  pst_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  pst_back #(
    .INDEX_BITS    (INDEX_BITS),
    .POSITION_BITS (POSITION_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tri_vert_a  (tri_vert_a),
    .tri_vert_b  (tri_vert_b),
    .tri_vert_c  (tri_vert_c),
    .src_pos_a   (src_pos_a),
    .src_pos_b   (src_pos_b),
    .src_pos_c   (src_pos_c),
    .face_number (face_number),
    .status      (status),
    .last        (last)
  );

endmodule
